// ===== hdl/dsirc_pkg.sv =====
// types, codes and the byte-wide crc-32 update for the dual slot record checker
// no dependencies
`timescale 1ns / 1ps

package dsirc_pkg;

    localparam logic [31:0] CRC_POLY    = 32'hedb8_8320;
    localparam logic [31:0] CRC_ONES    = 32'hffff_ffff;
    localparam logic [31:0] MAGIC_WORD  = 32'h5252_4944;
    localparam logic [7:0]  FORMAT_CODE = 8'd1;
    localparam logic [7:0]  MARKER_CODE = 8'd0;

    localparam logic [7:0] POS_FORMAT    = 8'd4;
    localparam logic [7:0] POS_ID_FIRST  = 8'd5;
    localparam logic [7:0] POS_ID_LAST   = 8'd20;
    localparam logic [7:0] POS_CRC_FIRST = 8'd21;
    localparam logic [7:0] POS_CRC_LAST  = 8'd24;
    localparam logic [7:0] POS_MARKER    = 8'd25;
    localparam logic [7:0] POS_MAX       = 8'd255;
    localparam logic [8:0] MIN_LEN       = 9'd26;

    localparam int ID_BYTES = 16;

    typedef enum logic [1:0] {
        STATUS_NONE     = 2'd0,
        STATUS_FOUND    = 2'd1,
        STATUS_CONFLICT = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       slot_end;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic        first_ok;
        logic        second_ok;
        logic [63:0] id_upper;
        logic [63:0] id_lower;
    } out_item_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        unique case (idx)
            2'd0: m = MAGIC_WORD[31:24];
            2'd1: m = MAGIC_WORD[23:16];
            2'd2: m = MAGIC_WORD[15:8];
            default: m = MAGIC_WORD[7:0];
        endcase
        return m;
    endfunction

endpackage

// ===== hdl/dual_slot_identity_record_check_core.sv =====
// dual slot identity record checker: byte stream in, one verdict per slot pair out
// depends on dsirc_pkg
// path: an accepted byte is held in the input register and processed from it;
//   a slot pair's verdict is registered in the output register
// throughput: one byte per cycle while no verdict waits on a stalled output;
//   the eight-step crc update works on the registered input byte
// reset: synchronous active-low aresetn returns to the first slot, offset zero
`timescale 1ns / 1ps

module dual_slot_identity_record_check_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dsirc_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dsirc_pkg::out_item_t m_data
);
    import dsirc_pkg::*;

    logic        in_valid_reg;
    in_item_t    in_data_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;

    logic        slot_reg, slot_next;
    logic [7:0]  pos_reg, pos_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] stored_reg, stored_next;
    logic        header_reg, header_next;
    logic        first_good_reg, first_good_next;
    logic [127:0] id_reg [2];

    logic        emits, proc, advance, ok;
    logic [7:0]  b, crc_off;
    logic [3:0]  id_idx;
    logic        id_write;
    out_item_t   result;

    assign b       = in_data_reg.data_byte;
    assign emits   = in_data_reg.slot_end && slot_reg;
    assign advance = !out_valid_reg || m_ready;
    assign proc    = in_valid_reg && (!emits || advance);
    assign s_ready = !in_valid_reg || proc;
    assign crc_off = pos_reg - POS_CRC_FIRST;
    assign id_idx  = 4'(pos_reg - POS_ID_FIRST);
    assign id_write = proc && (pos_reg >= POS_ID_FIRST) && (pos_reg <= POS_ID_LAST);

    // per-byte field checks and running state
    always_comb begin
        header_next = header_reg;
        stored_next = stored_reg;
        crc_next    = crc_reg;
        if (pos_reg < POS_FORMAT) begin
            if (b != magic_byte(pos_reg[1:0])) header_next = 1'b0;
        end else if (pos_reg == POS_FORMAT) begin
            if (b != FORMAT_CODE) header_next = 1'b0;
        end else if (pos_reg >= POS_CRC_FIRST && pos_reg <= POS_CRC_LAST) begin
            stored_next = stored_reg | ({24'd0, b} << {crc_off[1:0], 3'd0});
        end else if (pos_reg == POS_MARKER) begin
            if (b != MARKER_CODE) header_next = 1'b0;
        end
        if (pos_reg <= POS_ID_LAST) crc_next = crc_byte(crc_reg, b);
        pos_next = (pos_reg < POS_MAX) ? pos_reg + 8'd1 : pos_reg;
        ok = header_next && ({1'b0, pos_reg} + 9'd1 >= MIN_LEN)
            && ((crc_next ^ CRC_ONES) == stored_next);

        slot_next       = slot_reg;
        first_good_next = first_good_reg;
        if (in_data_reg.slot_end) begin
            slot_next       = !slot_reg;
            first_good_next = slot_reg ? 1'b0 : ok;
            pos_next        = 8'd0;
            crc_next        = CRC_ONES;
            stored_next     = 32'd0;
            header_next     = 1'b1;
        end
    end

    // verdict for the slot pair
    always_comb begin
        result.first_ok  = first_good_reg;
        result.second_ok = ok;
        result.status    = STATUS_NONE;
        result.id_upper  = 64'd0;
        result.id_lower  = 64'd0;
        priority if (first_good_reg && ok && (id_reg[0] != id_reg[1])) begin
            result.status = STATUS_CONFLICT;
        end else if (first_good_reg) begin
            result.status = STATUS_FOUND;
            {result.id_upper, result.id_lower} = id_reg[0];
        end else if (ok) begin
            result.status = STATUS_FOUND;
            {result.id_upper, result.id_lower} = id_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_reg       <= 1'b0;
            pos_reg        <= 8'd0;
            crc_reg        <= CRC_ONES;
            stored_reg     <= 32'd0;
            header_reg     <= 1'b1;
            first_good_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (proc) begin
                in_valid_reg <= 1'b0;
            end
            if (proc && emits) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (proc) begin
                slot_reg       <= slot_next;
                pos_reg        <= pos_next;
                crc_reg        <= crc_next;
                stored_reg     <= stored_next;
                header_reg     <= header_next;
                first_good_reg <= first_good_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_data_reg <= s_data;
        if (proc && emits) out_data_reg <= result;
        for (int k = 0; k < ID_BYTES; k++) begin
            if (id_write && id_idx == 4'(k)) id_reg[slot_reg][127 - 8*k -: 8] <= b;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_conflict_both_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STATUS_CONFLICT) |-> (m_data.first_ok && m_data.second_ok))
        else $error("conflict without two good slots");

    a_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != STATUS_FOUND) |-> (m_data.id_upper == 64'd0
            && m_data.id_lower == 64'd0))
        else $error("identity not cleared");

    a_none_no_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STATUS_NONE) |-> (!m_data.first_ok && !m_data.second_ok))
        else $error("status none with a good slot");

    a_in_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("transfer lost at input register");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !(proc && emits))
        else $error("result overwritten while stalled");

endmodule
